/* rtl/utf8_escape_stream_segmenter_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the terminal stream segmenter.
// They expect signals named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef UTF8_ESCAPE_STREAM_SEGMENTER_TOP_DEFINES_SVH
`define UTF8_ESCAPE_STREAM_SEGMENTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define UES_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ues_pkg.sv */
// ----------------------------------------------------------------------------
// ues_pkg
// Shared constants and types of the terminal stream segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package ues_pkg;

    localparam int LENGTH_BITS = 16;
    // Worst case per byte: lead byte plus four continuation bytes, then one more token.
    localparam int MAX_TOKENS  = 6;
    localparam int CNT_W       = $clog2(MAX_TOKENS + 1);

    typedef enum logic [2:0] {
        TK_RUNE   = 3'd0,
        TK_NONMIN = 3'd1,
        TK_RAW    = 3'd2,
        TK_ESC    = 3'd3,
        TK_END    = 3'd4
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t              kind;
        logic [30:0]            cp;
        logic [LENGTH_BITS-1:0] len;
        logic                   last;
    } token_t;

endpackage

`default_nettype wire

/* rtl/ues_stream_if.sv */
// ----------------------------------------------------------------------------
// ues_stream_if
// Valid/ready channels: the byte stream in and the token stream out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ues_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface ues_out_if import ues_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [2:0]             token_kind;
    logic [30:0]            code_point;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   last_of_run;

    modport source (output valid, output token_kind, output code_point,
                    output token_length, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input code_point,
                    input token_length, input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/utf8_escape_stream_segmenter_top.sv */
// ----------------------------------------------------------------------------
// utf8_escape_stream_segmenter_top
// Splits terminal output bytes into UTF-8 runes, raw bytes and escape sequences.
// ----------------------------------------------------------------------------
// A stream byte is parsed in the cycle it is taken: the parser state and a
// six-entry token register are updated at that edge. Each token leaves on the
// output channel one per cycle while tokens.ready is high, the last one of a
// byte marked by last_of_run. Plain text and escape sequences run at one byte
// per clock while the token side is ready; a byte that yields more than one
// token (a broken rune dumps its bytes, an end item flushes) holds the input
// while the token register drains. A new byte is taken in the same cycle as
// the last pending token moves out.
`default_nettype none

module utf8_escape_stream_segmenter_top
    import ues_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ues_in_if.sink    stream,
    ues_out_if.source tokens
);

    typedef enum logic [3:0] {
        M_IDLE, M_UTF, M_ESC, M_INTER, M_FINAL1, M_VT52, M_CSI, M_STR,
        M_STR_ESC, M_OSC0, M_PAL, M_OSC_STR, M_OSC_ESC, M_LB0, M_LB_DIG
    } mode_t;

    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_Y      = 8'h59;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [2:0] PAL_BYTES = 3'd7;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    function automatic logic [2:0] min_len(input logic [30:0] v);
        logic [2:0] n;
        if (v < 31'h80)             n = 3'd1;
        else if (v < 31'h800)       n = 3'd2;
        else if (v < 31'h10000)     n = 3'd3;
        else if (v < 31'h200000)    n = 3'd4;
        else if (v < 31'h4000000)   n = 3'd5;
        else                        n = 3'd6;
        return n;
    endfunction

    // Continuation byte idx (1 = first after the lead) rebuilt from the accumulator.
    function automatic logic [7:0] cont_byte(input logic [30:0] acc,
                                             input logic [2:0] seen,
                                             input logic [2:0] idx);
        logic [2:0] grp;
        logic [5:0] bits;
        grp = seen - idx;
        case (grp)
            3'd0:    bits = acc[5:0];
            3'd1:    bits = acc[11:6];
            3'd2:    bits = acc[17:12];
            3'd3:    bits = acc[23:18];
            default: bits = acc[29:24];
        endcase
        return {2'b10, bits};
    endfunction

    mode_t                  mode_reg, mode_next;
    logic [7:0]             lead_reg, lead_next;
    logic [30:0]            acc_reg, acc_next;
    logic [2:0]             exp_reg, exp_next;
    logic [2:0]             seen_reg, seen_next;
    logic [LENGTH_BITS-1:0] seq_reg, seq_next;
    token_t                 outq_reg [MAX_TOKENS];
    token_t                 outq_next [MAX_TOKENS];
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [7:0]             b;
    logic                   take;
    logic                   pop;

    // decode of a byte seen from the idle state
    logic                   id_emit;
    tok_kind_t              id_kind;
    logic                   id_esc;
    logic                   id_utf;
    logic [30:0]            id_acc;
    logic [2:0]             id_exp;

    logic [30:0]            cont_acc;
    logic [2:0]             cont_seen;
    logic                   rune_done;
    logic [2:0]             rune_m;
    logic [LENGTH_BITS-1:0] seq_inc;

    logic                   idle_go;
    logic                   do_idle;
    logic                   pre_dump;
    logic                   pre_esc;
    logic                   tail_en;
    token_t                 tail_tok;
    logic [CNT_W-1:0]       pre_cnt;
    logic [CNT_W-1:0]       tok_cnt;
    token_t                 list [MAX_TOKENS];

    assign b    = stream.data_byte;
    assign pop  = tokens.valid && tokens.ready;
    assign take = stream.valid && stream.ready;

    assign stream.ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && tokens.ready);

    assign tokens.valid        = (cnt_reg != '0);
    assign tokens.token_kind   = outq_reg[0].kind;
    assign tokens.code_point   = outq_reg[0].cp;
    assign tokens.token_length = outq_reg[0].len;
    assign tokens.last_of_run  = outq_reg[0].last;

    always_comb
    begin
        id_emit = 1'b0;
        id_kind = TK_RAW;
        id_esc  = 1'b0;
        id_utf  = 1'b0;
        id_acc  = '0;
        id_exp  = '0;
        if (b[7:6] == 2'b10)
        begin
            id_emit = 1'b1;
        end
        else if (!b[7])
        begin
            if (b == CH_ESC)
            begin
                id_esc = 1'b1;
            end
            else
            begin
                id_emit = 1'b1;
                id_kind = TK_RUNE;
            end
        end
        else if (!b[5])
        begin
            id_utf = 1'b1;
            id_acc = {26'd0, b[4:0]};
            id_exp = 3'd1;
        end
        else if (!b[4])
        begin
            id_utf = 1'b1;
            id_acc = {27'd0, b[3:0]};
            id_exp = 3'd2;
        end
        else if (!b[3])
        begin
            id_utf = 1'b1;
            id_acc = {28'd0, b[2:0]};
            id_exp = 3'd3;
        end
        else if (!b[2])
        begin
            id_utf = 1'b1;
            id_acc = {29'd0, b[1:0]};
            id_exp = 3'd4;
        end
        else if (!b[1])
        begin
            id_utf = 1'b1;
            id_acc = {30'd0, b[0]};
            id_exp = 3'd5;
        end
        else
        begin
            // 0xFE and 0xFF
            id_emit = 1'b1;
        end
    end

    assign cont_acc  = {acc_reg[24:0], b[5:0]};
    assign cont_seen = seen_reg + 3'd1;
    assign rune_done = (cont_seen >= exp_reg);
    assign rune_m    = exp_reg + 3'd1;
    assign seq_inc   = (seq_reg == LEN_MAX) ? seq_reg : seq_reg + 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        lead_next = lead_reg;
        acc_next  = acc_reg;
        exp_next  = exp_reg;
        seen_next = seen_reg;
        seq_next  = seq_reg;
        idle_go   = 1'b0;
        do_idle   = 1'b0;
        pre_dump  = 1'b0;
        pre_esc   = 1'b0;
        tail_en   = 1'b0;
        tail_tok  = '{kind: TK_END, cp: '0, len: '0, last: 1'b0};

        if (stream.cmd)
        begin
            if (mode_reg == M_UTF)
                pre_dump = 1'b1;
            else if (mode_reg != M_IDLE)
                pre_esc = 1'b1;
            idle_go = 1'b1;
            tail_en = 1'b1;
        end
        else
        begin
            if (mode_reg != M_IDLE && mode_reg != M_UTF)
                seq_next = seq_inc;
            case (mode_reg)
                M_IDLE:
                begin
                    do_idle = 1'b1;
                end
                M_UTF:
                begin
                    if (b[7:6] != 2'b10)
                    begin
                        pre_dump = 1'b1;
                        idle_go  = 1'b1;
                        do_idle  = 1'b1;
                    end
                    else
                    begin
                        acc_next  = cont_acc;
                        seen_next = cont_seen;
                        if (rune_done)
                        begin
                            tail_en       = 1'b1;
                            tail_tok.kind = (min_len(cont_acc) == rune_m) ? TK_RUNE : TK_NONMIN;
                            tail_tok.cp   = cont_acc;
                            tail_tok.len  = LENGTH_BITS'(rune_m);
                            idle_go       = 1'b1;
                        end
                    end
                end
                M_ESC:
                begin
                    if (b == CH_N || b == CH_O)
                        mode_next = M_FINAL1;
                    else if (b == CH_P || b == CH_X || b == CH_CARET || b == CH_UNDER)
                        mode_next = M_STR;
                    else if (b == CH_Y)
                        mode_next = M_VT52;
                    else if (b == CH_LBRK)
                        mode_next = M_CSI;
                    else if (b == CH_RBRK)
                        mode_next = M_OSC0;
                    else if (b == CH_LBRACE)
                        mode_next = M_LB0;
                    else if (b < CH_0)
                        mode_next = M_INTER;
                    else
                        tail_en = 1'b1;
                end
                M_INTER:
                begin
                    if (b >= CH_0)
                        tail_en = 1'b1;
                end
                M_FINAL1:
                begin
                    tail_en = 1'b1;
                end
                M_VT52:
                begin
                    mode_next = M_FINAL1;
                end
                M_CSI:
                begin
                    if (b >= CH_AT)
                        tail_en = 1'b1;
                end
                M_STR:
                begin
                    if (b == CH_ESC)
                        mode_next = M_STR_ESC;
                end
                M_STR_ESC:
                begin
                    if (b == CH_BSLASH)
                        tail_en = 1'b1;
                    else if (b != CH_ESC)
                        mode_next = M_STR;
                end
                M_OSC0:
                begin
                    if (b == CH_P)
                    begin
                        mode_next = M_PAL;
                        seen_next = '0;
                    end
                    else if ((b >= CH_0 && b <= CH_9) || b == CH_SEMI)
                        mode_next = M_OSC_STR;
                    else
                        tail_en = 1'b1;
                end
                M_PAL:
                begin
                    seen_next = cont_seen;
                    if (cont_seen == PAL_BYTES)
                        tail_en = 1'b1;
                end
                M_OSC_STR:
                begin
                    if (b == CH_BEL)
                        tail_en = 1'b1;
                    else if (b == CH_ESC)
                        mode_next = M_OSC_ESC;
                end
                M_OSC_ESC:
                begin
                    if (b == CH_BSLASH || b == CH_BEL)
                        tail_en = 1'b1;
                    else if (b != CH_ESC)
                        mode_next = M_OSC_STR;
                end
                M_LB0:
                begin
                    if (b == CH_A || b == CH_R || b == CH_T)
                        mode_next = M_LB_DIG;
                    else
                        tail_en = 1'b1;
                end
                M_LB_DIG:
                begin
                    if (!(b >= CH_0 && b <= CH_9))
                        tail_en = 1'b1;
                end
                default:
                begin
                    idle_go = 1'b1;
                end
            endcase

            // sequence finished in an escape mode
            if (tail_en && mode_reg != M_UTF)
            begin
                tail_tok.kind = TK_ESC;
                tail_tok.len  = seq_inc;
                idle_go       = 1'b1;
            end
        end

        if (idle_go)
        begin
            mode_next = M_IDLE;
            lead_next = '0;
            acc_next  = '0;
            exp_next  = '0;
            seen_next = '0;
            seq_next  = '0;
        end

        if (do_idle)
        begin
            tail_en       = id_emit;
            tail_tok.kind = id_kind;
            tail_tok.cp   = {23'd0, b};
            tail_tok.len  = LENGTH_BITS'(1);
            if (id_esc)
            begin
                mode_next = M_ESC;
                seq_next  = LENGTH_BITS'(1);
            end
            if (id_utf)
            begin
                mode_next = M_UTF;
                lead_next = b;
                acc_next  = id_acc;
                exp_next  = id_exp;
                seen_next = '0;
            end
        end
    end

    // Token list for this byte: an optional prefix (dumped rune bytes or a
    // flushed sequence), then an optional closing token.
    always_comb
    begin
        if (pre_dump)
            pre_cnt = CNT_W'(seen_reg) + CNT_W'(1);
        else if (pre_esc)
            pre_cnt = CNT_W'(1);
        else
            pre_cnt = '0;
        tok_cnt = pre_cnt + CNT_W'(tail_en);

        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            if (CNT_W'(i) < pre_cnt)
            begin
                list[i].kind = pre_esc ? TK_ESC : TK_RAW;
                list[i].len  = pre_esc ? seq_reg : LENGTH_BITS'(1);
                if (pre_esc)
                    list[i].cp = '0;
                else if (i == 0)
                    list[i].cp = {23'd0, lead_reg};
                else
                    list[i].cp = {23'd0, cont_byte(acc_reg, seen_reg, 3'(i))};
            end
            else
            begin
                list[i].kind = tail_tok.kind;
                list[i].cp   = tail_tok.cp;
                list[i].len  = tail_tok.len;
            end
            list[i].last = (CNT_W'(i) == tok_cnt - CNT_W'(1));
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_TOKENS; i++)
            outq_next[i] = outq_reg[i];
        if (take)
        begin
            cnt_next = tok_cnt;
            for (int i = 0; i < MAX_TOKENS; i++)
                outq_next[i] = list[i];
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < MAX_TOKENS - 1; i++)
                outq_next[i] = outq_reg[i + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            lead_reg <= '0;
            acc_reg  <= '0;
            exp_reg  <= '0;
            seen_reg <= '0;
            seq_reg  <= '0;
            cnt_reg  <= '0;
            for (int i = 0; i < MAX_TOKENS; i++)
                outq_reg[i] <= '0;
        end
        else
        begin
            if (take)
            begin
                mode_reg <= mode_next;
                lead_reg <= lead_next;
                acc_reg  <= acc_next;
                exp_reg  <= exp_next;
                seen_reg <= seen_next;
                seq_reg  <= seq_next;
            end
            cnt_reg <= cnt_next;
            for (int i = 0; i < MAX_TOKENS; i++)
                outq_reg[i] <= outq_next[i];
        end
    end

endmodule

`default_nettype wire

/* rtl/ues_checker.sv */
// ----------------------------------------------------------------------------
// ues_checker
// Port-level checks of the segmenter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_escape_stream_segmenter_top_defines.svh"

module ues_checker
    import ues_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_cmd,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [2:0]             token_kind,
    input logic [30:0]            code_point,
    input logic [LENGTH_BITS-1:0] token_length,
    input logic                   last_of_run
);

    // stalled token holds
    `UES_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(code_point) && $stable(token_length) && $stable(last_of_run), "token changed while stalled")

    // an end item always yields at least the end token
    `UES_ASSERT_NXT(a_end_yields, in_valid && in_ready && in_cmd, out_valid, "no token after end transfer")

    `UES_ASSERT_IMP(a_end_token, out_valid && token_kind == TK_END, last_of_run && token_length == '0 && code_point == '0, "malformed end token")

    // more tokens of the same byte are pending: no new byte may enter
    `UES_ASSERT_IMP(a_run_blocks, out_valid && !last_of_run, !in_ready, "input taken mid-run")

endmodule

bind utf8_escape_stream_segmenter_top ues_checker u_ues_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (stream.valid),
    .in_ready     (stream.ready),
    .in_cmd       (stream.cmd),
    .out_valid    (tokens.valid),
    .out_ready    (tokens.ready),
    .token_kind   (tokens.token_kind),
    .code_point   (tokens.code_point),
    .token_length (tokens.token_length),
    .last_of_run  (tokens.last_of_run)
);

`default_nettype wire

/* sim/ues_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ues_tb_pkg
// Stream item codes and control bytes shared by the segmenter testbench files.
// ----------------------------------------------------------------------------

package ues_tb_pkg;

    // cmd field of an input item
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] BEL_BYTE = 8'h07;

endpackage

/* sim/ues_token_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ues_token_checker
// Watches the byte and token channels, runs its own tokenizer on every byte
// transfer and compares each token transfer field by field with the oldest
// predicted token.
// ----------------------------------------------------------------------------

module ues_token_checker
    import ues_pkg::*;
    import ues_tb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ues_in_if    in_mon,
    ues_out_if   out_mon,
    output int   fail_count,
    output int   pending
);

    typedef enum logic [3:0] {
        PM_IDLE,
        PM_UTF,
        PM_ESC,
        PM_INTER,
        PM_FINAL1,
        PM_VT52,
        PM_CSI,
        PM_STR,
        PM_STR_ESC,
        PM_OSC0,
        PM_PAL,
        PM_OSC_STR,
        PM_OSC_ESC,
        PM_LB0,
        PM_LB_DIG
    } parse_mode_t;

    localparam logic [LENGTH_BITS-1:0] LEN_SAT = '1;

    parse_mode_t            mode;
    logic [7:0]             lead;
    logic [30:0]            acc;
    logic [2:0]             need;
    logic [2:0]             seen;
    logic [LENGTH_BITS-1:0] seq_len;

    token_t run_buf [0:MAX_TOKENS-1];
    int     run_n;
    token_t expected_tokens [$];
    token_t want;

    function automatic int shortest_len(input logic [30:0] r);
        if (r < 31'h80)      return 1;
        if (r < 31'h800)     return 2;
        if (r < 31'h10000)   return 3;
        if (r < 31'h200000)  return 4;
        if (r < 31'h4000000) return 5;
        return 6;
    endfunction

    function automatic bit is_digit(input logic [7:0] v);
        return v >= "0" && v <= "9";
    endfunction

    task automatic clear_state();
        mode    = PM_IDLE;
        lead    = '0;
        acc     = '0;
        need    = '0;
        seen    = '0;
        seq_len = '0;
    endtask

    task automatic add_token(input tok_kind_t k, input logic [30:0] value,
                             input logic [LENGTH_BITS-1:0] nbytes);
        run_buf[run_n] = '{kind: k, cp: value, len: nbytes, last: 1'b0};
        run_n++;
    endtask

    task automatic close_sequence();
        add_token(TK_ESC, '0, seq_len);
        clear_state();
    endtask

    // lead byte, then the continuation bytes rebuilt from the accumulator
    task automatic dump_partial_rune();
        int sh;
        add_token(TK_RAW, {23'd0, lead}, 1);
        for (int i = 0; i < int'(seen); i++) begin
            sh = 6 * (int'(seen) - 1 - i);
            add_token(TK_RAW, {23'd0, 2'b10, 6'(acc >> sh)}, 1);
        end
        clear_state();
    endtask

    task automatic start_byte(input logic [7:0] b);
        int ones;
        if (b[7:6] == 2'b10) begin
            add_token(TK_RAW, {23'd0, b}, 1);
        end else if (!b[7]) begin
            if (b == ESC_BYTE) begin
                mode    = PM_ESC;
                seq_len = 1;
            end else begin
                add_token(TK_RUNE, {23'd0, b}, 1);
            end
        end else begin
            ones = 0;
            while (ones < 8 && b[7-ones])
                ones++;
            if (ones > 6) begin
                add_token(TK_RAW, {23'd0, b}, 1);
            end else begin
                mode = PM_UTF;
                lead = b;
                acc  = 31'(b & (8'h7F >> ones));
                need = 3'(ones - 1);
                seen = '0;
            end
        end
    endtask

    task automatic predict_tokens(input logic c, input logic [7:0] b);
        tok_kind_t k;
        run_n = 0;
        if (c == CMD_END) begin
            if (mode == PM_UTF)
                dump_partial_rune();
            else if (mode != PM_IDLE)
                close_sequence();
            clear_state();
            add_token(TK_END, '0, '0);
        end else begin
            case (mode)
                PM_IDLE: start_byte(b);
                PM_UTF:
                begin
                    if (b[7:6] != 2'b10) begin
                        dump_partial_rune();
                        start_byte(b);
                    end else begin
                        acc  = {acc[24:0], b[5:0]};
                        seen = seen + 3'd1;
                        if (seen >= need) begin
                            k = (shortest_len(acc) == int'(need) + 1) ? TK_RUNE : TK_NONMIN;
                            add_token(k, acc, LENGTH_BITS'(int'(need) + 1));
                            clear_state();
                        end
                    end
                end
                default:
                begin
                    if (seq_len != LEN_SAT)
                        seq_len = seq_len + 1'b1;
                    case (mode)
                        PM_ESC:
                        begin
                            if (b == "N" || b == "O")
                                mode = PM_FINAL1;
                            else if (b == "P" || b == "X" || b == "^" || b == "_")
                                mode = PM_STR;
                            else if (b == "Y")
                                mode = PM_VT52;
                            else if (b == "[")
                                mode = PM_CSI;
                            else if (b == "]")
                                mode = PM_OSC0;
                            else if (b == "{")
                                mode = PM_LB0;
                            else if (b < "0")
                                mode = PM_INTER;
                            else
                                close_sequence();
                        end
                        PM_INTER:   if (b >= "0") close_sequence();
                        PM_FINAL1:  close_sequence();
                        PM_VT52:    mode = PM_FINAL1;
                        PM_CSI:     if (b >= "@") close_sequence();
                        PM_STR:     if (b == ESC_BYTE) mode = PM_STR_ESC;
                        PM_STR_ESC:
                        begin
                            if (b == "\\")
                                close_sequence();
                            else if (b != ESC_BYTE)
                                mode = PM_STR;
                        end
                        PM_OSC0:
                        begin
                            if (b == "P") begin
                                mode = PM_PAL;
                                seen = '0;
                            end else if (is_digit(b) || b == ";") begin
                                mode = PM_OSC_STR;
                            end else begin
                                close_sequence();
                            end
                        end
                        // palette: done on the seventh byte after P
                        PM_PAL:
                        begin
                            seen = seen + 3'd1;
                            if (seen == 3'd7)
                                close_sequence();
                        end
                        PM_OSC_STR:
                        begin
                            if (b == BEL_BYTE)
                                close_sequence();
                            else if (b == ESC_BYTE)
                                mode = PM_OSC_ESC;
                        end
                        PM_OSC_ESC:
                        begin
                            if (b == "\\" || b == BEL_BYTE)
                                close_sequence();
                            else if (b != ESC_BYTE)
                                mode = PM_OSC_STR;
                        end
                        PM_LB0:
                        begin
                            if (b == "A" || b == "R" || b == "T")
                                mode = PM_LB_DIG;
                            else
                                close_sequence();
                        end
                        PM_LB_DIG:  if (!is_digit(b)) close_sequence();
                        default:    clear_state();
                    endcase
                end
            endcase
        end
        if (run_n > 0)
            run_buf[run_n-1].last = 1'b1;
        for (int i = 0; i < run_n; i++)
            expected_tokens.push_back(run_buf[i]);
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, what, exp_val, act_val);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            clear_state();
            fail_count = 0;
        end else begin
            if (in_mon.valid && in_mon.ready)
                predict_tokens(in_mon.cmd, in_mon.data_byte);
            if (out_mon.valid && out_mon.ready) begin
                if (expected_tokens.size() == 0) begin
                    fail_count++;
                    $display("%0t: token with none expected, expected none, actual %0d/%0h/%0d/%0b",
                             $time, out_mon.token_kind, out_mon.code_point,
                             out_mon.token_length, out_mon.last_of_run);
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", 32'(want.kind), 32'(out_mon.token_kind));
                    check_field("code_point", 32'(want.cp), 32'(out_mon.code_point));
                    check_field("token_length", 32'(want.len), 32'(out_mon.token_length));
                    check_field("last_of_run", 32'(want.last), 32'(out_mon.last_of_run));
                end
            end
        end
        pending = expected_tokens.size();
    end

endmodule

/* sim/tb_utf8_escape_stream_segmenter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_escape_stream_segmenter_top
// Drives the terminal stream segmenter with directed and random byte streams
// (runes, broken runes, stray bytes, every escape form, flushes) under random
// idling on both channels; the checker judges tokens.
// ----------------------------------------------------------------------------

module tb_utf8_escape_stream_segmenter_top;

    import ues_pkg::*;
    import ues_tb_pkg::*;

    localparam realtime HALF_PERIOD      = 6;
    localparam int      RANDOM_ITEMS     = 400;
    localparam int      LONG_HOLD_CYCLES = 300;
    localparam int      TAIL_CYCLES      = 20;
    localparam longint  TIMEOUT_NS       = 12_000_000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ues_in_if  byte_ch ();
    ues_out_if token_ch ();

    int fail_count;
    int pending;
    int in_gap_max    = 14;
    int out_gap_max   = 14;
    int hold_requests = 0;
    int holds_done    = 0;
    int sent          = 0;

    always #(HALF_PERIOD) clk = ~clk;

    utf8_escape_stream_segmenter_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (byte_ch),
        .tokens (token_ch)
    );

    ues_token_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (byte_ch),
        .out_mon    (token_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // valid stays high into the next item when there is no gap
    task automatic send_item(input logic c, input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        repeat (gap) begin
            @(negedge clk);
            byte_ch.valid <= 1'b0;
        end
        @(negedge clk);
        byte_ch.valid     <= 1'b1;
        byte_ch.cmd       <= c;
        byte_ch.data_byte <= b;
        do @(posedge clk); while (!byte_ch.ready);
        sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(CMD_BYTE, b);
    endtask

    task automatic send_end();
        send_item(CMD_END, 8'($urandom));
    endtask

    task automatic stop_input();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
    endtask

    task automatic send_rune(input int nbytes, input bit shortest);
        logic [31:0] lo, hi, cp;
        case (nbytes)
            1:       begin lo = 32'h0;       hi = 32'h7F;       end
            2:       begin lo = 32'h80;      hi = 32'h7FF;      end
            3:       begin lo = 32'h800;     hi = 32'hFFFF;     end
            4:       begin lo = 32'h10000;   hi = 32'h1FFFFF;   end
            5:       begin lo = 32'h200000;  hi = 32'h3FFFFFF;  end
            default: begin lo = 32'h4000000; hi = 32'h7FFFFFFF; end
        endcase
        // overlong: value that fits a shorter encoding
        if (!shortest && nbytes > 1) begin
            hi = lo - 1;
            lo = 0;
        end
        cp = $urandom_range(hi, lo);
        if (nbytes == 1) begin
            send_byte(cp[7:0]);
        end else begin
            send_byte(8'((32'hFF << (8 - nbytes)) | (cp >> (6 * (nbytes - 1)))));
            for (int k = nbytes - 2; k >= 0; k--)
                send_byte(8'h80 | 8'((cp >> (6 * k)) & 32'h3F));
        end
    endtask

    task automatic send_broken_rune();
        int nbytes, kept;
        nbytes = $urandom_range(2, 6);
        kept   = $urandom_range(0, nbytes - 2);
        send_byte(8'((32'hFF << (8 - nbytes)) | $urandom_range(0, (1 << (7 - nbytes)) - 1)));
        repeat (kept) send_byte(8'($urandom_range(8'h80, 8'hBF)));
        case ($urandom_range(0, 2))
            0:       send_byte(8'($urandom_range(0, 8'h7F)));
            1:       send_byte(8'($urandom_range(8'hC0, 8'hFF)));
            default: send_end();
        endcase
    endtask

    task automatic send_escape();
        int n;
        send_byte(ESC_BYTE);
        case ($urandom_range(0, 10))
            0:
            begin
                n = $urandom_range(0, 3);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0)
                        send_byte(ESC_BYTE);
                    else
                        send_byte(8'($urandom_range(8'h20, 8'h2F)));
                end
                send_byte(8'($urandom_range(8'h30, 8'h7E)));
            end
            1:
            begin
                send_byte($urandom_range(0, 1) ? "N" : "O");
                send_byte(8'($urandom));
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       send_byte("P");
                    1:       send_byte("X");
                    2:       send_byte("^");
                    default: send_byte("_");
                endcase
                n = $urandom_range(0, 8);
                repeat (n) send_byte(8'($urandom));
                if ($urandom_range(0, 9) != 0) begin
                    send_byte(ESC_BYTE);
                    send_byte("\\");
                end
            end
            3:
            begin
                send_byte("[");
                n = $urandom_range(0, 4);
                repeat (n) send_byte(8'($urandom_range(8'h20, 8'h3F)));
                send_byte(8'($urandom_range(8'h40, 8'hFF)));
            end
            4:
            begin
                send_byte("]");
                n = $urandom_range(0, 10);
                send_byte(n == 10 ? ";" : 8'("0" + n));
                n = $urandom_range(0, 6);
                repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7E)));
                case ($urandom_range(0, 2))
                    0: send_byte(BEL_BYTE);
                    1: begin send_byte(ESC_BYTE); send_byte("\\"); end
                    default: begin send_byte(ESC_BYTE); send_byte(BEL_BYTE); end
                endcase
            end
            5:
            begin
                send_byte("]");
                send_byte("P");
                repeat (7) send_byte(8'($urandom));
            end
            6:
            begin
                send_byte("]");
                send_byte(8'($urandom_range("Q", "~")));
            end
            7:
            begin
                send_byte("Y");
                send_byte(8'($urandom_range(8'h20, 8'h7E)));
                send_byte(8'($urandom_range(8'h20, 8'h7E)));
            end
            8:
            begin
                send_byte("{");
                case ($urandom_range(0, 2))
                    0:       send_byte("A");
                    1:       send_byte("R");
                    default: send_byte("T");
                endcase
                n = $urandom_range(0, 3);
                repeat (n) send_byte(8'($urandom_range("0", "9")));
                send_byte(8'($urandom));
            end
            9:
            begin
                send_byte("{");
                send_byte(8'($urandom_range("a", "z")));
            end
            default: send_byte(8'($urandom_range("0", 8'hFF)));
        endcase
    endtask

    // token side: random hold-off per transfer, long hold-off on request
    initial begin : token_sink
        int wait_cycles;
        token_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            if (holds_done != hold_requests) begin
                holds_done++;
                wait_cycles = LONG_HOLD_CYCLES;
            end else begin
                wait_cycles = $urandom_range(0, out_gap_max);
            end
            repeat (wait_cycles) begin
                @(negedge clk);
                token_ch.ready <= 1'b0;
            end
            @(negedge clk);
            token_ch.ready <= 1'b1;
            do @(posedge clk); while (!token_ch.valid);
        end
    end

    initial begin : stimulus
        int target;
        byte_ch.valid     = 1'b0;
        byte_ch.cmd       = CMD_BYTE;
        byte_ch.data_byte = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: byte extremes, strays, overlong and longest runes,
        // broken runes, flush inside a rune and inside a sequence
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'hFE);
        send_byte(8'h80);
        send_byte(8'hC0);
        send_byte(8'h80);
        send_byte(8'hFD);
        repeat (5) send_byte(8'hBF);
        send_byte(8'hFC);
        send_byte(8'h84);
        repeat (3) send_byte(8'h80);
        send_byte("A");
        send_byte(8'hE2);
        send_byte(8'h82);
        send_end();
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);
        send_byte("c");
        send_byte(ESC_BYTE);
        send_byte("[");
        send_end();
        stop_input();
        wait (pending == 0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin in_gap_max = 14; out_gap_max = 14; end
                1:       begin in_gap_max = 0;  out_gap_max = 0;  end
                2:       begin in_gap_max = 0;  out_gap_max = 14; end
                default: begin in_gap_max = 14; out_gap_max = 0;  end
            endcase
            // token side stalls while bytes keep coming: input backs up
            if (phase == 1) begin
                hold_requests++;
                repeat (40) send_byte(8'($urandom_range(8'h20, 8'h7E)));
            end
            target = sent + RANDOM_ITEMS / 4;
            while (sent < target) begin
                case ($urandom_range(0, 99)) inside
                    [0:24]:  send_byte(8'($urandom_range(8'h20, 8'h7E)));
                    [25:44]: send_rune($urandom_range(1, 6), 1'b1);
                    [45:51]: send_rune($urandom_range(2, 6), 1'b0);
                    [52:59]: send_broken_rune();
                    [60:65]:
                    begin
                        case ($urandom_range(0, 2))
                            0:       send_byte(8'($urandom_range(8'h80, 8'hBF)));
                            1:       send_byte(8'hFE);
                            default: send_byte(8'hFF);
                        endcase
                    end
                    [66:89]: send_escape();
                    [90:93]: send_end();
                    default: send_byte(8'($urandom));
                endcase
            end
            stop_input();
            wait (pending == 0);
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

/* utf8_escape_stream_segmenter_top.f */
+incdir+rtl
rtl/ues_pkg.sv
rtl/ues_stream_if.sv
rtl/utf8_escape_stream_segmenter_top.sv
rtl/ues_checker.sv
sim/ues_tb_pkg.sv
sim/ues_token_checker.sv
sim/tb_utf8_escape_stream_segmenter_top.sv
